// ===== hdl/rtp_pkg.sv =====
// types and constants for the radial / tangential gradient projection
// used by rtp_front, rtp_cell and radial_tangential_projection
package rtp_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COORD_BITS  = 12;
    localparam int CENTER_W    = 18;
    localparam int GAIN_W      = 16;
    localparam int RES_W       = 16;
    localparam int CFG_W       = 18;
    localparam int CFG_IDX_W   = 2;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd2;

    // offset from the center in q.4, signed
    localparam int DXW  = ((COORD_BITS + 5 > CENTER_W) ? COORD_BITS + 5 : CENTER_W) + 1;
    localparam int MW   = SAMPLE_BITS + DXW;
    localparam int DOTW = MW + 1;
    localparam int PW   = DOTW + GAIN_W;
    localparam int AW   = PW;
    localparam int LOW  = (AW + 1) / 2;
    localparam int HIW  = AW - LOW;
    localparam int SQW  = 2 * AW;
    localparam int SW   = 2 * DXW;
    // radius term scaled by 2^14 so that half steps of the result are integers
    localparam int RND_SH = 14;
    localparam int KW   = SW + RND_SH;
    localparam int RW   = ((SQW > KW + 2 * RES_W + 3) ? SQW : KW + 2 * RES_W + 3) + 2;

    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};

    typedef struct packed {
        logic [COORD_BITS-1:0]         pix_col;
        logic [COORD_BITS-1:0]         pix_row;
        logic signed [SAMPLE_BITS-1:0] grad_x;
        logic signed [SAMPLE_BITS-1:0] grad_y;
    } in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] radial;
        logic signed [RES_W-1:0] tangential;
    } out_t;

    // per-result search state handed from cell to cell
    typedef struct packed {
        logic signed [RW-1:0] rem;
        logic signed [RW-1:0] w;
        logic [RES_W-1:0]     q;
        logic                 neg;
    } lane_t;

    typedef struct packed {
        lane_t         rad;
        lane_t         tan;
        logic [KW-1:0] k;
        logic          zero;
    } stage_t;

endpackage

// ===== hdl/rtp_front.sv =====
// front pipeline: offsets, dot and cross products, gain, squares, search setup
// depends on rtp_pkg
module rtp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  rtp_pkg::in_t                   in_data,
    input  logic signed [rtp_pkg::CENTER_W-1:0] center_x,
    input  logic signed [rtp_pkg::CENTER_W-1:0] center_y,
    input  logic signed [rtp_pkg::GAIN_W-1:0]   gain,
    output logic                           out_valid,
    output rtp_pkg::stage_t                out_stage
);
    import rtp_pkg::*;

    localparam int NS = 8;

    logic [NS-1:0] vld_reg, vld_next;

    // stage 1
    logic signed [DXW-1:0]         dx_reg, dy_reg;
    logic signed [SAMPLE_BITS-1:0] gx_reg, gy_reg;
    // stage 2
    logic signed [MW-1:0] gxdx_reg, gydy_reg, gxdy_reg, gydx_reg;
    logic [SW-1:0]        sxx_reg, syy_reg;
    // stage 3
    logic signed [DOTW-1:0] dot_reg, crs_reg;
    logic [SW-1:0]          s3_reg;
    // stage 4
    logic signed [PW-1:0] prad_reg, ptan_reg;
    logic [SW-1:0]        s4_reg;
    logic                 nrad4_reg, ntan4_reg;
    // stage 5
    logic [AW-1:0] arad_reg, atan_reg;
    logic [SW-1:0] s5_reg;
    logic          nrad5_reg, ntan5_reg;
    // stage 6
    logic [2*HIW-1:0]     rhh_reg, thh_reg;
    logic [HIW+LOW-1:0]   rhl_reg, thl_reg;
    logic [2*LOW-1:0]     rll_reg, tll_reg;
    logic [SW-1:0]        s6_reg;
    logic                 nrad6_reg, ntan6_reg;
    // stage 7
    logic [SQW-1:0] rsq_reg, tsq_reg;
    logic [SW-1:0]  s7_reg;
    logic           nrad7_reg, ntan7_reg;
    // stage 8
    stage_t st_reg, st_next;

    logic signed [DXW-1:0] dx_next, dy_next;
    logic signed [SW-1:0]  sxx_full, syy_full;
    logic [KW-1:0]         k7;

    assign vld_next = {vld_reg[NS-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        dx_next = DXW'(signed'({1'b0, in_data.pix_col, 4'b0000})) - DXW'(center_x);
        dy_next = DXW'(signed'({1'b0, in_data.pix_row, 4'b0000})) - DXW'(center_y);
        sxx_full = SW'(dx_reg) * SW'(dx_reg);
        syy_full = SW'(dy_reg) * SW'(dy_reg);
        k7 = KW'(s7_reg) << RND_SH;
        st_next.k       = k7;
        st_next.zero    = (s7_reg == '0);
        st_next.rad.rem = signed'(RW'({1'b0, rsq_reg})) - signed'(RW'({1'b0, k7}));
        st_next.rad.w   = -signed'(RW'({1'b0, k7}));
        st_next.rad.q   = '0;
        st_next.rad.neg = nrad7_reg;
        st_next.tan.rem = signed'(RW'({1'b0, tsq_reg})) - signed'(RW'({1'b0, k7}));
        st_next.tan.w   = -signed'(RW'({1'b0, k7}));
        st_next.tan.q   = '0;
        st_next.tan.neg = ntan7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            gx_reg <= in_data.grad_x;
            gy_reg <= in_data.grad_y;

            gxdx_reg <= MW'(gx_reg) * MW'(dx_reg);
            gydy_reg <= MW'(gy_reg) * MW'(dy_reg);
            gxdy_reg <= MW'(gx_reg) * MW'(dy_reg);
            gydx_reg <= MW'(gy_reg) * MW'(dx_reg);
            sxx_reg  <= SW'(sxx_full);
            syy_reg  <= SW'(syy_full);

            dot_reg <= DOTW'(gxdx_reg) + DOTW'(gydy_reg);
            crs_reg <= DOTW'(gxdy_reg) - DOTW'(gydx_reg);
            s3_reg  <= sxx_reg + syy_reg;

            prad_reg  <= PW'(dot_reg) * PW'(gain);
            ptan_reg  <= PW'(crs_reg) * PW'(gain);
            nrad4_reg <= dot_reg[DOTW-1] ^ gain[GAIN_W-1];
            ntan4_reg <= crs_reg[DOTW-1] ^ gain[GAIN_W-1];
            s4_reg    <= s3_reg;

            arad_reg  <= prad_reg[PW-1] ? AW'(-prad_reg) : AW'(prad_reg);
            atan_reg  <= ptan_reg[PW-1] ? AW'(-ptan_reg) : AW'(ptan_reg);
            nrad5_reg <= nrad4_reg;
            ntan5_reg <= ntan4_reg;
            s5_reg    <= s4_reg;

            // square of the magnitude split into halves
            rhh_reg <= (2*HIW)'(arad_reg[AW-1:LOW]) * (2*HIW)'(arad_reg[AW-1:LOW]);
            rhl_reg <= (HIW+LOW)'(arad_reg[AW-1:LOW]) * (HIW+LOW)'(arad_reg[LOW-1:0]);
            rll_reg <= (2*LOW)'(arad_reg[LOW-1:0]) * (2*LOW)'(arad_reg[LOW-1:0]);
            thh_reg <= (2*HIW)'(atan_reg[AW-1:LOW]) * (2*HIW)'(atan_reg[AW-1:LOW]);
            thl_reg <= (HIW+LOW)'(atan_reg[AW-1:LOW]) * (HIW+LOW)'(atan_reg[LOW-1:0]);
            tll_reg <= (2*LOW)'(atan_reg[LOW-1:0]) * (2*LOW)'(atan_reg[LOW-1:0]);
            nrad6_reg <= nrad5_reg;
            ntan6_reg <= ntan5_reg;
            s6_reg    <= s5_reg;

            rsq_reg <= (SQW'(rhh_reg) << (2*LOW)) + (SQW'(rhl_reg) << (LOW+1))
                     + SQW'(rll_reg);
            tsq_reg <= (SQW'(thh_reg) << (2*LOW)) + (SQW'(thl_reg) << (LOW+1))
                     + SQW'(tll_reg);
            nrad7_reg <= nrad6_reg;
            ntan7_reg <= ntan6_reg;
            s7_reg    <= s6_reg;

            st_reg <= st_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_stage = st_reg;

endmodule

// ===== hdl/rtp_cell.sv =====
// one result bit of the rounded quotient search, for both results
// depends on rtp_pkg
module rtp_cell #(
    parameter int BIT = 0
) (
    input  logic            clk,
    input  logic            en,
    input  rtp_pkg::stage_t in_stage,
    output rtp_pkg::stage_t out_stage
);
    import rtp_pkg::*;

    stage_t st_reg, st_next;

    // try q + 2^BIT: rem tracks a^2 - (2q-1)^2 * k, w tracks (2q-1) * k
    function automatic lane_t step(input lane_t ln, input logic [KW-1:0] k);
        logic signed [RW-1:0] kx;
        logic signed [RW-1:0] delta;
        logic signed [RW-1:0] trial;
        lane_t                res;
        kx    = signed'(RW'({1'b0, k}));
        delta = (ln.w <<< (BIT + 2)) + (kx <<< (2 * BIT + 2));
        trial = ln.rem - delta;
        res   = ln;
        // once the top bit is set the value is at its cap
        if (!trial[RW-1] && !ln.q[RES_W-1])
        begin
            res.rem    = trial;
            res.w      = ln.w + (kx <<< (BIT + 1));
            res.q[BIT] = 1'b1;
        end
        return res;
    endfunction

    always_comb
    begin
        st_next     = in_stage;
        st_next.rad = step(in_stage.rad, in_stage.k);
        st_next.tan = step(in_stage.tan, in_stage.k);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign out_stage = st_reg;

endmodule

// ===== hdl/radial_tangential_projection.sv =====
// top level: config registers, front pipeline, chain of search cells, output skid
// depends on rtp_pkg, rtp_front, rtp_cell
//
//  channel | signals                       | direction | word
//  input   | in_valid, in_stall, in_data   | in        | in_t  (col, row, gx, gy)
//  output  | out_valid, out_stall, out_data| out       | out_t (radial, tangential)
//  config  | cfg_we, cfg_index, cfg_data   | in        | 18-bit register write
//
// one word per cycle while in_stall is low; path is 8 front stages + 16 cells + 1 output register
// each cell settles one result bit, the chain length follows the 16-bit result
// reset clears valid bits and config (center 0, gain 1.0); data registers are not reset
// a word arriving while the output word is stalled goes into a skid register; in_stall rises only while it is full
module radial_tangential_projection (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  rtp_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output rtp_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [rtp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtp_pkg::CFG_W-1:0]        cfg_data
);
    import rtp_pkg::*;

    logic signed [CENTER_W-1:0] center_x_reg, center_y_reg;
    logic signed [GAIN_W-1:0]   gain_reg;

    logic   en;
    logic   front_valid;
    stage_t chain [RES_W+1];
    logic [RES_W-1:0] cvld_reg;

    out_t fin_data;
    logic fin_valid;
    out_t out_reg, out_next, skid_reg, skid_next;
    logic out_vld_reg, out_vld_next, skid_vld_reg, skid_vld_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            gain_reg     <= GAIN_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_GAIN:     gain_reg     <= cfg_data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign en       = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    rtp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .gain      (gain_reg),
        .out_valid (front_valid),
        .out_stage (chain[0])
    );

    // most significant bit first
    for (genvar i = 0; i < RES_W; i++)
    begin : g_cell
        rtp_cell #(
            .BIT (RES_W - 1 - i)
        ) u_cell (
            .clk       (clk),
            .en        (en),
            .in_stage  (chain[i]),
            .out_stage (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvld_reg <= '0;
        end
        else if (en)
        begin
            cvld_reg <= {cvld_reg[RES_W-2:0], front_valid};
        end
    end

    function automatic logic [RES_W-1:0] finish(input lane_t ln, input logic zero);
        logic [RES_W-1:0] r;
        if (zero)
        begin
            r = '0;
        end
        else if (ln.neg)
        begin
            r = -ln.q;
        end
        else if (ln.q > RES_MAX)
        begin
            r = RES_MAX;
        end
        else
        begin
            r = ln.q;
        end
        return r;
    endfunction

    always_comb
    begin
        fin_valid           = cvld_reg[RES_W-1];
        fin_data.radial     = finish(chain[RES_W].rad, chain[RES_W].zero);
        fin_data.tangential = finish(chain[RES_W].tan, chain[RES_W].zero);

        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;
        if (en && fin_valid)
        begin
            if (!out_vld_reg || !out_stall)
            begin
                out_next     = fin_data;
                out_vld_next = 1'b1;
            end
            else
            begin
                skid_next     = fin_data;
                skid_vld_next = 1'b1;
            end
        end
        else if (out_vld_reg && !out_stall)
        begin
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word held without an output word");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && out_stall))
        else $error("skid filled while the output word was free");

    a_search_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid && chain[RES_W].rad.q[RES_W-1]) |-> (chain[RES_W].rad.q[RES_W-2:0] == '0))
        else $error("radial search passed its cap");

endmodule

// ===== tb/tb_radial_tangential_projection.sv =====
// self-checking bench for radial_tangential_projection: projection predictor, word checker
// depends on rtp_pkg and the radial_tangential_projection rtl
module tb_radial_tangential_projection;
    timeunit 1ns;
    timeprecision 1ps;
    import rtp_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 40;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    class projection_board;
        longint ctr_x;
        longint ctr_y;
        longint scale;
        out_t   expected_q[$];
        int     errors;

        function new();
            ctr_x = 0;
            ctr_y = 0;
            scale = 256;
            errors = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function automatic logic [63:0] mag(longint v);
            return (v < 0) ? 64'(-v) : 64'(v);
        endfunction

        // rounded, saturated dot*g / (256*sqrt(s)), by search on squared bounds
        function automatic logic signed [RES_W-1:0] project(longint dot, longint g,
                                                             logic [63:0] s);
            logic [127:0] p, n2, t, rhs;
            logic [16:0] lo, hi, mid;
            bit neg;
            neg = (dot < 0) != (g < 0);
            p = 128'(mag(dot)) * 128'(mag(g));
            n2 = p * p;
            lo = 0;
            hi = 32768;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                t = (128'(mid) * 2 - 1) * 128;
                rhs = t * t * 128'(s);
                if (n2 >= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            if (neg)
                return RES_W'(-longint'(lo));
            return (lo > 32767) ? RES_MAX : RES_W'(lo);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_CENTER_X)
                ctr_x = longint'(signed'(val[CENTER_W-1:0]));
            else if (idx == REG_CENTER_Y)
                ctr_y = longint'(signed'(val[CENTER_W-1:0]));
            else if (idx == REG_GAIN)
                scale = longint'(signed'(val[GAIN_W-1:0]));
        endfunction

        function void note_input(in_t w);
            longint dx4, dy4, gx, gy;
            logic [63:0] s;
            out_t r;
            gx = longint'(w.grad_x);
            gy = longint'(w.grad_y);
            dx4 = longint'(w.pix_col) * 16 - ctr_x;
            dy4 = longint'(w.pix_row) * 16 - ctr_y;
            s = 64'(dx4 * dx4) + 64'(dy4 * dy4);
            r = '0;
            if (s != 0)
            begin
                r.radial = project(gx * dx4 + gy * dy4, scale, s);
                r.tangential = project(gx * dy4 - gy * dx4, scale, s);
            end
            expected_q.push_back(r);
        endfunction

        task check_result(out_t got);
            out_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.radial !== want.radial)
                report($sformatf("radial %0d, want %0d", got.radial, want.radial));
            if (got.tangential !== want.tangential)
                report($sformatf("tangential %0d, want %0d", got.tangential,
                                 want.tangential));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_t                 out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    projection_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int cycle_count;

    radial_tangential_projection dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("tb_radial_tangential_projection: done, errors");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else
                out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
    end

    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task send_word(in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = w;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(w);
        @(negedge clk);
    endtask

    task send_fields(int col, int row, int gx, int gy);
        in_t w;
        w.pix_col = COORD_BITS'(col);
        w.pix_row = COORD_BITS'(row);
        w.grad_x = SAMPLE_BITS'(gx);
        w.grad_y = SAMPLE_BITS'(gy);
        send_word(w);
    endtask

    // waits out every expected word, then the pipeline depth
    task drain();
        in_valid = 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int pick_grad();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(8) - 4;
            default: return $urandom_range(65535) - 32768;
        endcase
    endfunction

    function automatic int pick_coord(longint ctr);
        case ($urandom_range(9))
            0: return 0;
            1: return 4095;
            2: return (ctr >= 0 && ctr < 65536) ? int'(ctr / 16) : 0;
            default: return $urandom_range(4095);
        endcase
    endfunction

    task random_cfg();
        write_cfg(REG_CENTER_X, ($urandom_range(3) == 0) ? CFG_W'($urandom)
                                : CFG_W'($urandom_range(4095) * 16 + $urandom_range(15)));
        write_cfg(REG_CENTER_Y, ($urandom_range(3) == 0) ? CFG_W'($urandom)
                                : CFG_W'($urandom_range(4095) * 16));
        write_cfg(REG_GAIN, CFG_W'($urandom_range(65535)));
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, center point, ties, extremes
        send_fields(0, 0, 1000, -1000);
        send_fields(3, 4, 300, 400);
        send_fields(4095, 4095, 32767, -32768);
        send_fields(4095, 0, -32768, -32768);
        send_fields(0, 4095, 32767, 32767);
        drain();
        write_cfg(REG_GAIN, CFG_W'(128));
        send_fields(1, 0, 1, 0);
        send_fields(1, 0, -1, 0);
        send_fields(0, 1, 3, -3);
        send_fields(1, 0, 32767, -32768);
        drain();
        write_cfg(REG_GAIN, CFG_W'(-32768));
        send_fields(1, 1, 32767, 32767);
        send_fields(1, 0, -32768, 5);
        drain();
        write_cfg(REG_CENTER_X, CFG_W'(131071));
        write_cfg(REG_CENTER_Y, CFG_W'(-131072));
        write_cfg(REG_GAIN, CFG_W'(32767));
        send_fields(0, 0, 32767, 1);
        send_fields(4095, 4095, -32768, 32767);
        drain();
        write_cfg(REG_CENTER_X, CFG_W'(100 * 16));
        write_cfg(REG_CENTER_Y, CFG_W'(200 * 16));
        write_cfg(REG_NONE, CFG_W'(7));
        send_fields(100, 200, 5000, 7000);
        send_fields(101, 200, 5000, 7000);
        send_fields(100, 201, -5000, 7000);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 3)
                0: begin send_idle_pct = 38; recv_idle_pct = 55; end
                1: begin send_idle_pct = 55; recv_idle_pct = 38; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 2)
            begin
                write_cfg(REG_CENTER_X, CFG_W'(-131072));
                write_cfg(REG_CENTER_Y, CFG_W'(131071));
                write_cfg(REG_GAIN, CFG_W'(-32768));
            end
            else if (ph > 0)
                random_cfg();
            if (ph == 5)
                hold_cycles = 300;
            for (int i = 0; i < 190; i++)
                send_fields(pick_coord(board.ctr_x), pick_coord(board.ctr_y),
                            pick_grad(), pick_grad());
            drain();
        end

        if (board.errors == 0)
            $display("tb_radial_tangential_projection: done, clean");
        else
            $display("tb_radial_tangential_projection: done, errors");
        $finish;
    end
endmodule
